FILE: hw/rtl/sha1md_pkg.sv
`default_nettype none

package sha1md_pkg;

    localparam int WORD_W     = 32;
    localparam int HASH_WORDS = 5;
    localparam int SCHED_LEN  = 16;
    localparam int ROUND_W    = 7;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 61;
    localparam int LEN_W      = 64;
    localparam int IDX_W      = 3;
    localparam int OUT_DATA_W = 40;

    typedef logic [WORD_W-1:0]      t_word;
    typedef t_word [HASH_WORDS-1:0] t_hash;

    localparam t_hash H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
    localparam logic [ROUND_W-1:0] ROUND_B1    = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_B2    = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_B3    = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;

    localparam logic [7:0]       PAD_BYTE = 8'h80;
    localparam logic [POS_W-1:0] POS_LAST = 6'd63;
    localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [ROUND_W-1:0]   round;
    } t_round_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/sha1md_word_cell.sv
`default_nettype none

// One 32-bit word of the schedule line; takes its neighbor's word when shifted.
module sha1md_word_cell (
    input  wire                      i_clk,
    input  wire                      i_shift,
    input  wire sha1md_pkg::t_word   i_d,
    output sha1md_pkg::t_word        o_q
);

    sha1md_pkg::t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

`default_nettype wire

FILE: hw/rtl/sha1md_round.sv
`default_nettype none

// Working variables a..e and one SHA-1 round per step.
module sha1md_round (
    input  wire                          i_clk,
    input  wire sha1md_pkg::t_round_ctl  i_ctl,
    input  wire sha1md_pkg::t_hash       i_h,
    input  wire sha1md_pkg::t_word       i_w,
    output sha1md_pkg::t_hash            o_v
);

    sha1md_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    sha1md_pkg::t_word f, k, t;

    always_comb begin
        if (i_ctl.round < sha1md_pkg::ROUND_B1) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = sha1md_pkg::K_0;
        end else if (i_ctl.round < sha1md_pkg::ROUND_B2) begin
            f = r_b ^ r_c ^ r_d;
            k = sha1md_pkg::K_1;
        end else if (i_ctl.round < sha1md_pkg::ROUND_B3) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = sha1md_pkg::K_2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = sha1md_pkg::K_3;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + i_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_h[0];
            r_b <= i_h[1];
            r_c <= i_h[2];
            r_d <= i_h[3];
            r_e <= i_h[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= t;
        end
    end

    assign o_v = {r_e, r_d, r_c, r_b, r_a};

endmodule

`default_nettype wire

FILE: hw/rtl/sha1_message_digest_top.sv
`default_nettype none

// SHA-1 digest engine over a byte stream.
// Slave channel: one request per byte. s_axis_tdata is the byte, s_axis_tuser
// says the byte is part of the message (0 lets a request close a message with
// no byte), s_axis_tlast closes the message.
// Master channel: five requests per message, digest words high word first;
// tdata carries the word and its number, tlast flags the fifth word.
// Bytes go into a 16-cell word shift line; the same line produces the message
// schedule while a block is compressed at one round per cycle.
// Bytes are taken one per cycle while idle; the byte that fills a block starts
// the rounds and then the chaining add, during which no byte is taken, so the
// single round unit sets the rate.
// End of message: padding runs one byte per cycle up to the end of the block
// (one or two blocks, each followed by compression and the chaining add), then
// the digest words are offered, one per cycle while the receiver takes them.
// The slave side is held off while compressing, padding and delivering.
// A receiver stall simply holds the current digest word; nothing is lost.
// Reset (synchronous, active low) loads the initial chaining value and clears
// the byte count; the same happens after the last digest word is taken.
module sha1_message_digest_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  wire         s_axis_tuser,   // [0] byte_present
    input  wire         s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [sha1md_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [31:0] digest_word,
                                                            // [34:32] word_number
    output logic        m_axis_tlast    // final_word
);

    sha1md_pkg::t_state r_state, n_state;

    logic [sha1md_pkg::POS_W-1:0]   r_pos;
    logic [sha1md_pkg::COUNT_W-1:0] r_count, count_next;
    logic [sha1md_pkg::LEN_W-1:0]   r_len, len_shift;
    logic [23:0]                    r_acc;
    logic                           r_first;     // next pad byte is the 0x80 marker
    logic                           r_len_ok;    // length may go into this block
    logic                           r_go_out;    // this block is the final one
    logic                           r_go_pad;    // padding follows this block
    logic [sha1md_pkg::ROUND_W-1:0] r_round;
    logic [sha1md_pkg::IDX_W-1:0]   r_idx;
    sha1md_pkg::t_hash              r_h;

    logic              in_req, out_req;
    logic              byte_we, block_full, push, chain_en;
    logic [7:0]        byte_val;
    sha1md_pkg::t_word chain_in, sched, push_word, out_word;
    sha1md_pkg::t_hash work_v;
    sha1md_pkg::t_round_ctl round_ctl;
    sha1md_pkg::t_word q [sha1md_pkg::SCHED_LEN];

    assign in_req     = s_axis_tvalid & s_axis_tready;
    assign out_req    = m_axis_tvalid & m_axis_tready;
    assign count_next = r_count + {{(sha1md_pkg::COUNT_W-1){1'b0}}, s_axis_tuser};
    assign len_shift  = r_len >> {3'(~r_pos[2:0]), 3'b000};

    // Control: next state and per-cycle strobes.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        byte_we       = 1'b0;
        byte_val      = s_axis_tdata;
        round_ctl     = '0;
        unique case (r_state)
            sha1md_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                byte_we       = in_req & s_axis_tuser;
            end
            sha1md_pkg::ST_PAD: begin
                byte_we = 1'b1;
                if (r_first) begin
                    byte_val = sha1md_pkg::PAD_BYTE;
                end else if (r_len_ok && r_pos[5:3] == 3'b111) begin
                    byte_val = len_shift[7:0];
                end else begin
                    byte_val = 8'h00;
                end
            end
            sha1md_pkg::ST_COMPRESS: begin
                round_ctl.step = 1'b1;
                if (r_round == sha1md_pkg::ROUND_LAST) begin
                    n_state = sha1md_pkg::ST_ADD;
                end
            end
            sha1md_pkg::ST_ADD: begin
                if (r_go_out) begin
                    n_state = sha1md_pkg::ST_OUT;
                end else if (r_go_pad) begin
                    n_state = sha1md_pkg::ST_PAD;
                end else begin
                    n_state = sha1md_pkg::ST_IDLE;
                end
            end
            sha1md_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (out_req && r_idx == sha1md_pkg::IDX_LAST) begin
                    n_state = sha1md_pkg::ST_IDLE;
                end
            end
            default: n_state = sha1md_pkg::ST_IDLE;
        endcase

        block_full = byte_we & (r_pos == sha1md_pkg::POS_LAST);
        if (block_full) begin
            n_state = sha1md_pkg::ST_COMPRESS;
        end else if (r_state == sha1md_pkg::ST_IDLE && in_req && s_axis_tlast) begin
            n_state = sha1md_pkg::ST_PAD;
        end
        round_ctl.load  = block_full;
        round_ctl.round = r_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Byte position, message count, padding flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_count  <= '0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
            r_go_out <= 1'b0;
            r_go_pad <= 1'b0;
        end else begin
            if (byte_we) begin
                r_pos <= r_pos + 1'b1;
            end
            if (r_state == sha1md_pkg::ST_IDLE && in_req) begin
                r_count <= count_next;
                if (s_axis_tlast) begin
                    r_first  <= 1'b1;
                    r_len_ok <= 1'b0;
                end
            end
            if (r_state == sha1md_pkg::ST_PAD) begin
                r_first <= 1'b0;
                if (r_pos == sha1md_pkg::POS_LAST) begin
                    r_len_ok <= 1'b1;
                end else if (r_first) begin
                    r_len_ok <= (r_pos[5:3] != 3'b111);
                end
            end
            if (block_full) begin
                r_go_out <= (r_state == sha1md_pkg::ST_PAD) & r_len_ok & ~r_first;
                // a pad block without the length needs one more pad block
                r_go_pad <= ((r_state == sha1md_pkg::ST_IDLE) & s_axis_tlast)
                            | ((r_state == sha1md_pkg::ST_PAD) & ~(r_len_ok & ~r_first));
            end
            if (r_state == sha1md_pkg::ST_OUT && out_req
                && r_idx == sha1md_pkg::IDX_LAST) begin
                r_pos   <= '0;
                r_count <= '0;
            end
        end
    end

    // Bit length is latched at the end request.
    always_ff @(posedge i_clk) begin
        if (r_state == sha1md_pkg::ST_IDLE && in_req && s_axis_tlast) begin
            r_len <= {count_next, 3'b000};
        end
        if (byte_we) begin
            r_acc <= {r_acc[15:0], byte_val};
        end
    end

    // Round counter and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_idx   <= '0;
            r_h     <= sha1md_pkg::H_INIT;
        end else begin
            if (block_full) begin
                r_round <= '0;
            end else if (r_state == sha1md_pkg::ST_COMPRESS) begin
                r_round <= r_round + 1'b1;
            end
            if (r_state == sha1md_pkg::ST_ADD) begin
                for (int i = 0; i < sha1md_pkg::HASH_WORDS; i++) begin
                    r_h[i] <= r_h[i] + work_v[i];
                end
            end
            if (out_req) begin
                if (r_idx == sha1md_pkg::IDX_LAST) begin
                    r_idx <= '0;
                    r_h   <= sha1md_pkg::H_INIT;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Schedule line: loads packed words, then rotates / extends during rounds.
    assign push      = byte_we & (r_pos[1:0] == 2'b11);
    assign push_word = {r_acc, byte_val};
    assign sched     = (r_round < sha1md_pkg::ROUND_SCHED) ? q[0] :
                       sha1md_pkg::t_word'({q[13] ^ q[8] ^ q[2] ^ q[0],
                                            q[13][31] ^ q[8][31] ^ q[2][31] ^ q[0][31]}
                                           & 33'h0_FFFF_FFFF);
    assign chain_en  = push | (r_state == sha1md_pkg::ST_COMPRESS);
    assign chain_in  = (r_state == sha1md_pkg::ST_COMPRESS) ? sched : push_word;

    for (genvar g = 0; g < sha1md_pkg::SCHED_LEN; g++) begin : g_cell
        sha1md_word_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (chain_en),
            .i_d     ((g == sha1md_pkg::SCHED_LEN - 1) ? chain_in
                                                       : q[(g + 1) % sha1md_pkg::SCHED_LEN]),
            .o_q     (q[g])
        );
    end

    sha1md_round u_round (
        .i_clk (i_clk),
        .i_ctl (round_ctl),
        .i_h   (r_h),
        .i_w   (sched),
        .o_v   (work_v)
    );

    // Digest output.
    always_comb begin
        unique case (r_idx)
            3'd0:    out_word = r_h[0];
            3'd1:    out_word = r_h[1];
            3'd2:    out_word = r_h[2];
            3'd3:    out_word = r_h[3];
            3'd4:    out_word = r_h[4];
            default: out_word = r_h[0];
        endcase
    end

    assign m_axis_tdata = {5'b00000, r_idx, out_word};
    assign m_axis_tlast = (r_idx == sha1md_pkg::IDX_LAST);

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1md_pkg::ST_COMPRESS && r_round == sha1md_pkg::ROUND_LAST)
        |=> r_state == sha1md_pkg::ST_ADD)
        else $error("compression did not end after the last round");

    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        block_full |=> (r_state == sha1md_pkg::ST_COMPRESS && r_round == '0 && r_pos == '0))
        else $error("full block did not start compression");

    a_out_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1md_pkg::ST_OUT) |-> (r_pos == '0 && r_idx <= sha1md_pkg::IDX_LAST))
        else $error("digest offered with a partial block");

    a_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_req && m_axis_tlast) |=> (r_state == sha1md_pkg::ST_IDLE && r_count == '0
                                       && r_h == sha1md_pkg::H_INIT))
        else $error("engine not restarted after the last digest word");

endmodule

`default_nettype wire
